// ----- sv/wspl_pkg.sv -----
// Package for the wheel speed PID loop: register indexes, reset values,
// field widths and shared types. No dependencies.

package wspl_pkg;

    // Field widths
    localparam int TARGET_W = 22;
    localparam int RATE_W   = 10;
    localparam int GAIN_W   = 32;
    localparam int LIMIT_W  = 31;
    localparam int DUTY_W   = 17;
    localparam int PULSE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Internal datapath widths
    localparam int ERR_W   = 27;   // target minus speed
    localparam int SUM_W   = 32;   // clamped error sum
    localparam int RAW_W   = 33;   // sum before clamp
    localparam int DRV_W   = 28;   // e minus last error
    localparam int OPB_W   = 33;   // signed multiplier operand
    localparam int PROD_W  = 66;   // signed multiplier product
    localparam int ACC_W   = 67;   // sum of three products

    // Full duty, Q1.16
    localparam logic [DUTY_W-1:0] FULL_DUTY = 17'd65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_DT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_OVER_DT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX       = 3'd6;

    // Register reset values
    localparam logic [TARGET_W-1:0] RST_TARGET_SPEED   = 22'd3500;
    localparam logic [RATE_W-1:0]   RST_RATE_SCALE     = 10'd100;
    localparam logic [GAIN_W-1:0]   RST_GAIN_P         = 32'd1677722;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I_DT      = 32'd8389;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D_OVER_DT = 32'd16777216;
    localparam logic [LIMIT_W-1:0]  RST_SUM_LIMIT      = 31'd100000;
    localparam logic [DUTY_W-1:0]   RST_DUTY_MAX       = 17'd65536;

    typedef logic signed [OPB_W-1:0]  opb_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ----- sv/wheel_speed_pid_loop.sv -----
// Wheel speed PID loop, top level: config registers, sequencer, datapath.
// Depends on wspl_pkg and wspl_mul.
//
// Usage: one instance per wheel. Each control tick, present the signed
// encoder pulse count of the last period on pulses_in_period with
// pulses_valid; the word is taken when pulses_stall is low. The block
// returns one word: duty (Q1.16, 65536 is full) and sum_clamped, under
// result_valid, held until result_stall is low at a clock edge.
// Gains and limits are written over the cfg channel (cfg_ready is always
// high); write them only while no word is in flight.
// Steps per word: SPEED, ERR, CLAMP, MUL_I, MUL_D, ACC, DONE; result_valid
// rises as DONE is left, once the output is free. One word at a time:
// pulses_stall stays high from the cycle after accept until the result is
// loaded into the output register, so no new word is taken before then. The
// pace is set by the single shared multiplier, used four times (speed, P, I
// and D terms), with the sum and clamp steps in between.
// If the receiver stalls, the finished word waits in the output register;
// a new input word is still taken, and its result waits in the last step
// until the output register frees up.
// Reset (rst_n low, asynchronous) restores the register defaults, clears
// the error sum and last error, and drops result_valid.

module wheel_speed_pid_loop (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 pulses_valid,
    output logic                                 pulses_stall,
    input  logic signed [wspl_pkg::PULSE_W-1:0]  pulses_in_period,
    // result channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [wspl_pkg::DUTY_W-1:0]          duty,
    output logic                                 sum_clamped,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wspl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wspl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SPEED = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd2;
    localparam logic [3:0] ST_CLAMP = 4'd3;
    localparam logic [3:0] ST_MUL_I = 4'd4;
    localparam logic [3:0] ST_MUL_D = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    // Configuration registers
    logic [wspl_pkg::TARGET_W-1:0] target_speed_reg;
    logic [wspl_pkg::RATE_W-1:0]   rate_scale_reg;
    logic [wspl_pkg::GAIN_W-1:0]   gain_p_reg;
    logic [wspl_pkg::GAIN_W-1:0]   gain_i_dt_reg;
    logic [wspl_pkg::GAIN_W-1:0]   gain_d_over_dt_reg;
    logic [wspl_pkg::LIMIT_W-1:0]  sum_limit_reg;
    logic [wspl_pkg::DUTY_W-1:0]   duty_max_reg;

    // Control state
    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    // Loop state
    logic signed [wspl_pkg::SUM_W-1:0] error_sum_reg;
    logic signed [wspl_pkg::SUM_W-1:0] error_sum_next;
    logic signed [wspl_pkg::ERR_W-1:0] last_error_reg;
    logic signed [wspl_pkg::ERR_W-1:0] last_error_next;

    // Per-word payload
    logic signed [wspl_pkg::PULSE_W-1:0] pulses_reg;
    logic signed [wspl_pkg::ERR_W-1:0]   err_reg;
    logic signed [wspl_pkg::ERR_W-1:0]   err_next;
    logic signed [wspl_pkg::RAW_W-1:0]   raw_sum_reg;
    logic signed [wspl_pkg::RAW_W-1:0]   raw_sum_next;
    logic signed [wspl_pkg::DRV_W-1:0]   deriv_reg;
    logic signed [wspl_pkg::DRV_W-1:0]   deriv_next;
    logic                                clamp_flag_reg;
    logic                                clamp_flag_next;
    logic signed [wspl_pkg::ACC_W-1:0]   acc_reg;
    logic signed [wspl_pkg::ACC_W-1:0]   acc_next;
    logic [wspl_pkg::DUTY_W-1:0]         duty_reg;
    logic [wspl_pkg::DUTY_W-1:0]         duty_next;
    logic                                sum_clamped_reg;

    // Multiplier operands and product
    logic [wspl_pkg::GAIN_W-1:0] mul_a;
    wspl_pkg::opb_t              mul_b;
    wspl_pkg::prod_t             mul_p;

    // Helpers
    logic                                in_accept;
    logic                                out_free;
    logic signed [wspl_pkg::ERR_W-1:0]   speed;
    logic signed [wspl_pkg::RAW_W-1:0]   lim_pos;
    logic signed [wspl_pkg::RAW_W-1:0]   lim_neg;
    logic [wspl_pkg::DUTY_W-1:0]         cap;
    logic [wspl_pkg::DUTY_W-1:0]         trunc;

    assign in_accept = pulses_valid && !pulses_stall;
    assign out_free  = !result_valid_reg || !result_stall;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg   <= wspl_pkg::RST_TARGET_SPEED;
            rate_scale_reg     <= wspl_pkg::RST_RATE_SCALE;
            gain_p_reg         <= wspl_pkg::RST_GAIN_P;
            gain_i_dt_reg      <= wspl_pkg::RST_GAIN_I_DT;
            gain_d_over_dt_reg <= wspl_pkg::RST_GAIN_D_OVER_DT;
            sum_limit_reg      <= wspl_pkg::RST_SUM_LIMIT;
            duty_max_reg       <= wspl_pkg::RST_DUTY_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wspl_pkg::REG_TARGET_SPEED:
                    target_speed_reg <= cfg_data[wspl_pkg::TARGET_W-1:0];
                wspl_pkg::REG_RATE_SCALE:
                    rate_scale_reg <= cfg_data[wspl_pkg::RATE_W-1:0];
                wspl_pkg::REG_GAIN_P:
                    gain_p_reg <= cfg_data;
                wspl_pkg::REG_GAIN_I_DT:
                    gain_i_dt_reg <= cfg_data;
                wspl_pkg::REG_GAIN_D_OVER_DT:
                    gain_d_over_dt_reg <= cfg_data;
                wspl_pkg::REG_SUM_LIMIT:
                    sum_limit_reg <= cfg_data[wspl_pkg::LIMIT_W-1:0];
                wspl_pkg::REG_DUTY_MAX:
                    duty_max_reg <= cfg_data[wspl_pkg::DUTY_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Multiplier operand select per step
    always_comb
    begin
        unique case (state_reg)
            ST_SPEED:
            begin
                mul_a = wspl_pkg::GAIN_W'(rate_scale_reg);
                mul_b = wspl_pkg::OPB_W'(pulses_reg);
            end
            ST_CLAMP:
            begin
                mul_a = gain_p_reg;
                mul_b = wspl_pkg::OPB_W'(err_reg);
            end
            ST_MUL_I:
            begin
                mul_a = gain_i_dt_reg;
                mul_b = wspl_pkg::OPB_W'(error_sum_reg);
            end
            default:
            begin
                mul_a = gain_d_over_dt_reg;
                mul_b = wspl_pkg::OPB_W'(deriv_reg);
            end
        endcase
    end

    wspl_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // Error, raw sum, clamp and derivative
    assign speed   = mul_p[wspl_pkg::ERR_W-1:0];
    assign lim_pos = $signed({2'b00, sum_limit_reg});
    assign lim_neg = -lim_pos;

    // Duty conversion: Q.24 total to Q1.16, negative to zero, clamped to the ceiling
    assign cap   = (duty_max_reg > wspl_pkg::FULL_DUTY) ? wspl_pkg::FULL_DUTY : duty_max_reg;
    assign trunc = acc_reg[24:8];

    always_comb
    begin
        err_next        = err_reg;
        raw_sum_next    = raw_sum_reg;
        deriv_next      = deriv_reg;
        clamp_flag_next = clamp_flag_reg;
        error_sum_next  = error_sum_reg;
        last_error_next = last_error_reg;
        acc_next        = acc_reg;
        duty_next       = duty_reg;

        unique case (state_reg)
            ST_ERR:
            begin
                err_next     = wspl_pkg::ERR_W'($signed({1'b0, target_speed_reg}) - speed);
                raw_sum_next = wspl_pkg::RAW_W'(error_sum_reg)
                             + wspl_pkg::RAW_W'(wspl_pkg::ERR_W'(
                                   $signed({1'b0, target_speed_reg}) - speed));
            end
            ST_CLAMP:
            begin
                priority if (raw_sum_reg > lim_pos)
                begin
                    error_sum_next  = lim_pos[wspl_pkg::SUM_W-1:0];
                    clamp_flag_next = 1'b1;
                end
                else if (raw_sum_reg < lim_neg)
                begin
                    error_sum_next  = lim_neg[wspl_pkg::SUM_W-1:0];
                    clamp_flag_next = 1'b1;
                end
                else
                begin
                    error_sum_next  = raw_sum_reg[wspl_pkg::SUM_W-1:0];
                    clamp_flag_next = 1'b0;
                end
                deriv_next      = wspl_pkg::DRV_W'(err_reg) - wspl_pkg::DRV_W'(last_error_reg);
                last_error_next = err_reg;
            end
            ST_MUL_I:
            begin
                acc_next = wspl_pkg::ACC_W'(mul_p);
            end
            ST_MUL_D, ST_ACC:
            begin
                acc_next = acc_reg + wspl_pkg::ACC_W'(mul_p);
            end
            ST_DONE:
            begin
                priority if (acc_reg[wspl_pkg::ACC_W-1])
                    duty_next = '0;
                else if (|acc_reg[wspl_pkg::ACC_W-2:25])
                    duty_next = cap;
                else if (trunc > cap)
                    duty_next = cap;
                else
                    duty_next = trunc;
            end
            default:
                ;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_SPEED;
            ST_SPEED: state_next = ST_ERR;
            ST_ERR:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_ACC;
            ST_ACC:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control and loop state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            error_sum_reg    <= '0;
            last_error_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            error_sum_reg    <= error_sum_next;
            last_error_reg   <= last_error_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            pulses_reg <= pulses_in_period;
        err_reg        <= err_next;
        raw_sum_reg    <= raw_sum_next;
        deriv_reg      <= deriv_next;
        clamp_flag_reg <= clamp_flag_next;
        acc_reg        <= acc_next;
        if (state_reg == ST_DONE && out_free)
        begin
            duty_reg        <= duty_next;
            sum_clamped_reg <= clamp_flag_reg;
        end
    end

    assign pulses_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign duty         = duty_reg;
    assign sum_clamped  = sum_clamped_reg;

endmodule

// ----- sv/wspl_mul.sv -----
// Shared registered multiplier for the wheel speed PID loop:
// unsigned 32-bit gain times signed 33-bit operand. Depends on wspl_pkg.

module wspl_mul (
    input  logic                           clk,
    input  logic [wspl_pkg::GAIN_W-1:0]    op_a,
    input  wspl_pkg::opb_t                 op_b,
    output wspl_pkg::prod_t                prod
);

    wspl_pkg::prod_t prod_reg;
    wspl_pkg::prod_t prod_next;

    // 33x33 signed multiply, unsigned side gets a zero sign bit
    always_comb
    begin
        prod_next = wspl_pkg::PROD_W'($signed({1'b0, op_a}) * op_b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- sv/wspl_checker.sv -----
// Port-level checker for the wheel speed PID loop, bound to the top level.
// Depends on wspl_pkg and wheel_speed_pid_loop.

module wspl_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 pulses_valid,
    input logic                                 pulses_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic [wspl_pkg::DUTY_W-1:0]          duty,
    input logic                                 sum_clamped
);

    // Busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pulses_valid && !pulses_stall) |=> pulses_stall)
        else $error("input not stalled after accept");

    // Duty never above full
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (duty <= wspl_pkg::FULL_DUTY))
        else $error("duty above full scale");

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(duty) && $stable(sum_clamped)))
        else $error("stalled result changed");

    // A new result only follows a word in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pulses_stall, 1))
        else $error("result without work in flight");

endmodule

bind wheel_speed_pid_loop wspl_checker u_wspl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pulses_valid     (pulses_valid),
    .pulses_stall     (pulses_stall),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .duty             (duty),
    .sum_clamped      (sum_clamped)
);
